>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, types and opcodes of the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int CAP_RESET  = 16;

    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS   = $clog2(ENTRIES + 1);

    // input word: key in the low bits, value above, padded to whole bytes
    localparam int IN_BITS    = KEY_BITS + VALUE_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic load_item;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic result_pending;
    } ctrl_status_t;

endpackage

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: takes one word, runs its lookup/update, owns output valid.
// ----------------------------------------------------------------------------
module lkv_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output lkv_pkg::ctrl_cmd_t cmd,
    output lkv_pkg::ctrl_status_t status
);
    import lkv_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   exec_fire;

    assign in_ready  = (state_reg == S_IDLE);
    // run the update only when the output register is free or draining
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign cmd.load_item = in_valid && in_ready;
    assign cmd.execute   = exec_fire;
    assign status.result_pending = out_valid_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load_item)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry store, parallel key match, recency ranks, capacity register and
// result register.
// ----------------------------------------------------------------------------
module lkv_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lkv_pkg::ctrl_cmd_t               cmd,
    input  lkv_pkg::ctrl_status_t            status,
    input  logic                             in_op,
    input  logic [lkv_pkg::KEY_BITS-1:0]     in_key,
    input  logic [lkv_pkg::VALUE_BITS-1:0]   in_value,
    input  logic                             cfg_we,
    input  logic [lkv_pkg::CAP_BITS-1:0]     cfg_capacity,
    output logic                             out_hit,
    output logic [lkv_pkg::VALUE_BITS-1:0]   out_read_value,
    output logic                             out_evicted
);
    import lkv_pkg::*;

    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic [KEY_BITS-1:0]   entry_key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] entry_value_reg [ENTRIES];
    logic [ENTRIES-1:0]    entry_valid_reg;
    logic [ENTRIES-1:0]    entry_valid_next;
    logic [IDX_BITS-1:0]   entry_rank_reg  [ENTRIES];
    logic [IDX_BITS-1:0]   entry_rank_next [ENTRIES];
    logic [OCC_BITS-1:0]   occ_reg;
    logic [OCC_BITS-1:0]   occ_next;
    logic [CAP_BITS-1:0]   cap_reg;

    logic                  hit_reg;
    logic                  evicted_reg;
    logic [VALUE_BITS-1:0] read_value_reg;

    logic [ENTRIES-1:0]    match;
    logic                  found;
    logic [IDX_BITS-1:0]   found_idx;
    logic [IDX_BITS-1:0]   victim_idx;
    logic [IDX_BITS-1:0]   oldest_rank;
    logic [OCC_BITS-1:0]   eff_cap;
    logic                  full;
    logic                  do_evict;
    logic                  do_fill;
    logic                  do_write;
    logic [IDX_BITS-1:0]   slot;
    logic [IDX_BITS-1:0]   old_rank;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = entry_valid_reg[i] && (entry_key_reg[i] == key_reg);
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        found     = |match;
        found_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = IDX_BITS'(i);
            end
        end
    end

    // ranks of valid entries are a permutation of 0..occ-1, so the oldest
    // holds occ-1
    assign oldest_rank = IDX_BITS'(occ_reg - OCC_BITS'(1));

    always_comb
    begin
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (entry_valid_reg[i] && (entry_rank_reg[i] == oldest_rank))
            begin
                victim_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = OCC_BITS'(1);
        end
        else if (cap_reg > CAP_BITS'(ENTRIES))
        begin
            eff_cap = OCC_BITS'(ENTRIES);
        end
        else
        begin
            eff_cap = OCC_BITS'(cap_reg);
        end
    end

    assign full     = (occ_reg >= eff_cap);
    assign do_evict = !found && (op_reg == OP_PUT) && full;
    assign do_fill  = !found && (op_reg == OP_PUT) && !full;
    assign do_write = do_evict || do_fill || (found && (op_reg == OP_PUT));

    // entries are never dropped, so valid slots form a prefix and the lowest
    // free slot is the occupancy count
    always_comb
    begin
        if (found)
        begin
            slot     = found_idx;
            old_rank = entry_rank_reg[found_idx];
        end
        else if (do_evict)
        begin
            slot     = victim_idx;
            old_rank = oldest_rank;
        end
        else
        begin
            slot     = occ_reg[IDX_BITS-1:0];
            old_rank = oldest_rank;
        end
    end

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        occ_next         = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_rank_next[i] = entry_rank_reg[i];
        end
        if (cmd.execute && (found || do_evict))
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_BITS'(i) == slot)
                begin
                    entry_rank_next[i] = '0;
                end
                else if (entry_valid_reg[i] && (entry_rank_reg[i] < old_rank))
                begin
                    entry_rank_next[i] = entry_rank_reg[i] + IDX_BITS'(1);
                end
            end
        end
        else if (cmd.execute && do_fill)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (IDX_BITS'(i) == slot)
                begin
                    entry_rank_next[i]  = '0;
                    entry_valid_next[i] = 1'b1;
                end
                else if (entry_valid_reg[i])
                begin
                    entry_rank_next[i] = entry_rank_reg[i] + IDX_BITS'(1);
                end
            end
            occ_next = occ_reg + OCC_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            occ_reg         <= '0;
            cap_reg         <= CAP_BITS'(CAP_RESET);
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_rank_reg[i] <= '0;
            end
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            occ_reg         <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_rank_reg[i] <= entry_rank_next[i];
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
        end
    end

    // payload: item, entry contents and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            value_reg <= in_value;
        end
        if (cmd.execute && do_write)
        begin
            entry_key_reg[slot]   <= key_reg;
            entry_value_reg[slot] <= value_reg;
        end
        if (cmd.execute)
        begin
            hit_reg     <= found;
            evicted_reg <= do_evict;
            if (found && (op_reg == OP_GET))
            begin
                read_value_reg <= entry_value_reg[found_idx];
            end
            else
            begin
                read_value_reg <= '0;
            end
        end
    end

    // drive zeros while no result is held
    assign out_hit        = hit_reg && status.result_pending;
    assign out_evicted    = evicted_reg && status.result_pending;
    assign out_read_value = status.result_pending ? read_value_reg : '0;

endmodule

>>> rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel  | signals                          | word contents (low bit up)
//  ---------+----------------------------------+------------------------------
//  request  | s_axis_tvalid/tready/tdata/tuser | tdata: key[15:0], value[47:16]
//           |                                  | tuser: op (0 get, 1 put)
//  result   | m_axis_tvalid/tready/tdata/tuser | tdata: read_value[31:0]
//           |                                  | tuser: hit[0], evicted[1]
//  config   | cfg_valid/cfg_ready/cfg_data     | capacity[4:0], always ready
//
//  Each request is handled in order: the word is captured first, then come the
//  parallel key match, rank update and entry write into the result register.
//  The next request is taken while the previous result waits on m_axis_tready;
//  the update stalls only when a result is still held and not taken.
//  Reset clears valid bits, ranks and occupancy at once; capacity resets to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lkv_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // key, value
    input  logic                                s_axis_tuser,  // op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lkv_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // read_value
    output logic [1:0]                          m_axis_tuser,  // hit, evicted
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkv_pkg::CAP_BITS-1:0]        cfg_data
);
    import lkv_pkg::*;

    ctrl_cmd_t             cmd;
    ctrl_status_t          status;
    logic                  hit;
    logic                  evicted;
    logic [VALUE_BITS-1:0] read_value;

    assign cfg_ready = 1'b1;

    lkv_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    lkv_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_op          (s_axis_tuser),
        .in_key         (s_axis_tdata[KEY_BITS-1:0]),
        .in_value       (s_axis_tdata[IN_BITS-1:KEY_BITS]),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_capacity   (cfg_data),
        .out_hit        (hit),
        .out_read_value (read_value),
        .out_evicted    (evicted)
    );

    assign m_axis_tdata = OUT_TDATA_W'(read_value);
    assign m_axis_tuser = {evicted, hit};

endmodule
